FILE: rtl/core/ssp_pkg.sv
// Shared slot pool: types, codes and constants used by all modules.
// No dependencies.
package ssp_pkg;

  localparam int POOL_SIZE  = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int ROUTE_BITS = 8;
  localparam int RID_W      = ROUTE_BITS + 1;
  localparam logic [RID_W-1:0] ROUTE_NONE = RID_W'(1) << ROUTE_BITS;

  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_BUSY   = 2'd1,
    ST_SOFT   = 2'd2,
    ST_REUSED = 2'd3
  } slot_state_t;

  typedef struct packed {
    slot_state_t      status;
    logic [RID_W-1:0] owner;
    logic [RID_W-1:0] borrower;
  } slot_t;

  localparam slot_t SLOT_RESET = '{status: ST_FREE, owner: ROUTE_NONE, borrower: ROUTE_NONE};

  localparam logic [2:0] FN_RESERVE  = 3'd0;
  localparam logic [2:0] FN_PREEMPT  = 3'd1;
  localparam logic [2:0] FN_HARD_REL = 3'd2;
  localparam logic [2:0] FN_SOFT_REL = 3'd3;
  localparam logic [2:0] FN_REL_ALL  = 3'd4;

  localparam logic [2:0] RS_OK        = 3'd0;
  localparam logic [2:0] RS_RES_SHORT = 3'd1;
  localparam logic [2:0] RS_PRE_EXC   = 3'd2;
  localparam logic [2:0] RS_HARD_EXC  = 3'd3;
  localparam logic [2:0] RS_SOFT_EXC  = 3'd4;

  localparam logic [0:0] REG_SLOTS = 1'b0;
  localparam logic [0:0] REG_KIND  = 1'b1;

  localparam logic [1:0] KIND_REPEATER = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN  = 2'd3;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_COUNT,
    SQ_APPLY,
    SQ_PLREAD,
    SQ_PLWAIT,
    SQ_HOLD,
    SQ_EMIT,
    SQ_FIN
  } seq_state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    slot_t            wdata;
    logic [IDX_W-1:0] raddr;
  } tbl_req_t;

endpackage

FILE: rtl/core/ssp_slot_table.sv
// Slot table: status, owner and borrower per slot, one write and one registered read.
// Uses ssp_pkg. Per-entry valid bits make unwritten slots read as Free / none.
module ssp_slot_table (
  input  logic              clk,
  input  logic              rst,
  input  ssp_pkg::tbl_req_t req,
  output ssp_pkg::slot_t    rdata
);

  ssp_pkg::slot_t                      mem [ssp_pkg::POOL_SIZE];
  logic [ssp_pkg::POOL_SIZE-1:0]       valid;
  ssp_pkg::slot_t                      rd_q;
  logic                                rd_valid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_q <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      rd_valid <= valid[req.raddr];
    end
  end

  assign rdata = rd_valid ? rd_q : ssp_pkg::SLOT_RESET;

endmodule

FILE: rtl/core/ssp_stop_list.sv
// List of evicted borrower routes from the last preempt; registered read.
// Uses ssp_pkg. Contents undefined until written.
module ssp_stop_list (
  input  logic                            clk,
  input  logic                            we,
  input  logic [ssp_pkg::IDX_W-1:0]       waddr,
  input  logic [ssp_pkg::RID_W-1:0]       wdata,
  input  logic [ssp_pkg::IDX_W-1:0]       raddr,
  output logic [ssp_pkg::RID_W-1:0]       rdata
);

  logic [ssp_pkg::RID_W-1:0] mem [ssp_pkg::POOL_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/shared_slot_pool_with_preemption.sv
// Shared slot pool with preemption: top level, sequencer and output register.
// Uses ssp_pkg, ssp_slot_table and ssp_stop_list.
//
// One operation at a time. A transfer on s_ starts a pass that reads every slot in
// use (n = min(slots_in_use, 64)) through the single slot table port and counts the
// candidates; if the operation fits, a second pass applies the moves, each slot read
// then written back in turn. An error or unknown code ends after the first pass. A
// preempt then walks the evicted borrower list: each borrower not marked none gets a
// further pass that counts its remaining holdings, unless the pool kind is unknown,
// and each stop result ahead of the final one goes out from the EMIT state; a held
// output register stalls the sequencer.
// s_tready is high only while the sequencer is idle;
// a finished result sits in the output register and the next operation may be
// taken while it waits. Results are one per operation, or for a preempt one per
// borrower to stop (in eviction order, duplicates kept), tlast on the final one.
module shared_slot_pool_with_preemption (
  input  logic        clk,
  input  logic        rst,
  // tdata: func[2:0], route[10:3], count[17:11], zero pad
  input  logic [23:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: status[2:0], stopped_route[10:3], free_count[17:11], zero pad
  output logic [23:0] m_tdata,
  // tuser: stop_valid
  output logic        m_tuser,
  output logic        m_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_wdata
);

  localparam int CW = ssp_pkg::CNT_W;
  localparam int IW = ssp_pkg::IDX_W;
  localparam int RW = ssp_pkg::RID_W;

  // configuration
  logic [CW-1:0] slots_in_use;
  logic [1:0]    pool_kind;
  logic [CW-1:0] n_act;

  // sequencer
  ssp_pkg::seq_state_t state, state_next;
  logic [2:0]    func;
  logic [RW-1:0] route;
  logic [CW-1:0] num;
  logic [CW-1:0] idx;
  logic          pend;
  logic [IW-1:0] pidx;
  logic          scan_go, scan_done;

  logic [CW-1:0] cnt  [4];
  logic [CW-1:0] rank [4];
  logic [CW-1:0] take [4];
  logic [CW-1:0] cf, nf, hold, pcount, k;
  logic [RW-1:0] pr;
  logic          have_pend;
  logic [ssp_pkg::ROUTE_BITS-1:0] pend_route;
  logic [2:0]    res_status;
  logic [CW-1:0] res_free;

  // output register
  logic          o_valid, o_sv, o_last;
  logic [2:0]    o_status;
  logic [ssp_pkg::ROUTE_BITS-1:0] o_route;
  logic [CW-1:0] o_free;
  logic          out_free;

  // storage
  ssp_pkg::tbl_req_t tbl_req;
  ssp_pkg::slot_t    e;
  logic          pl_we;
  logic [RW-1:0] pl_rdata;

  // per-slot evaluation
  logic [3:0]    m, q;
  ssp_pkg::slot_t v;
  logic [8:0]    cand_sum;
  logic          err, fn_bad, k_last, skip, hit;
  logic [CW-1:0] rem1, rem2, t0, t1, t2;
  logic [CW-1:0] thr;
  logic [2:0]    err_code;

  ssp_slot_table u_tbl (
    .clk   (clk),
    .rst   (rst),
    .req   (tbl_req),
    .rdata (e)
  );

  ssp_stop_list u_pl (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pcount[IW-1:0]),
    .wdata (e.borrower),
    .raddr (k[IW-1:0]),
    .rdata (pl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= CW'(ssp_pkg::POOL_SIZE);
      pool_kind    <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        ssp_pkg::REG_SLOTS: slots_in_use <= cfg_wdata;
        ssp_pkg::REG_KIND:  pool_kind    <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign n_act = (slots_in_use > CW'(ssp_pkg::POOL_SIZE)) ? CW'(ssp_pkg::POOL_SIZE)
                                                          : slots_in_use;

  // candidate classes per operation (bit i = list i)
  always_comb begin
    m = 4'b0000;
    case (func)
      ssp_pkg::FN_RESERVE: begin
        m[0] = (e.status == ssp_pkg::ST_FREE);
        m[1] = (e.status == ssp_pkg::ST_SOFT);
      end
      ssp_pkg::FN_PREEMPT: begin
        m[0] = (e.status == ssp_pkg::ST_SOFT)   && (e.owner == route);
        m[1] = (e.status == ssp_pkg::ST_REUSED) && (e.owner == route);
      end
      ssp_pkg::FN_HARD_REL: begin
        m[0] = (e.status == ssp_pkg::ST_REUSED) && (e.borrower == route);
        m[1] = (e.status == ssp_pkg::ST_REUSED) && (e.owner == route);
        m[2] = (e.status == ssp_pkg::ST_SOFT)   && (e.owner == route);
        m[3] = (e.status == ssp_pkg::ST_BUSY)   && (e.owner == route);
      end
      ssp_pkg::FN_SOFT_REL: begin
        m[0] = (e.status == ssp_pkg::ST_BUSY) && (e.owner == route);
      end
      default: m = 4'b0000;
    endcase
    for (int i = 0; i < 4; i++) begin
      q[i] = m[i] && (rank[i] < take[i]);
    end
  end

  // new value of the slot under the apply pass; list moves act in list order
  always_comb begin
    v = e;
    case (func)
      ssp_pkg::FN_RESERVE: begin
        if (q[0]) begin
          v.status = ssp_pkg::ST_BUSY;
          v.owner  = route;
        end else if (q[1]) begin
          v.status   = ssp_pkg::ST_REUSED;
          v.borrower = route;
        end
      end
      ssp_pkg::FN_PREEMPT: begin
        if (q[0]) begin
          v.status = ssp_pkg::ST_BUSY;
        end else if (q[1]) begin
          v.status   = ssp_pkg::ST_BUSY;
          v.borrower = ssp_pkg::ROUTE_NONE;
        end
      end
      ssp_pkg::FN_HARD_REL: begin
        if (q[0]) begin
          v.status   = ssp_pkg::ST_SOFT;
          v.borrower = ssp_pkg::ROUTE_NONE;
        end
        if (q[1]) begin
          v.status   = ssp_pkg::ST_BUSY;
          v.owner    = v.borrower;
          v.borrower = ssp_pkg::ROUTE_NONE;
        end
        if (q[2] || q[3]) begin
          v.status = ssp_pkg::ST_FREE;
          v.owner  = ssp_pkg::ROUTE_NONE;
        end
      end
      ssp_pkg::FN_SOFT_REL: begin
        if (q[0]) v.status = ssp_pkg::ST_SOFT;
      end
      ssp_pkg::FN_REL_ALL: begin
        if (e.owner == route) begin
          if (e.status == ssp_pkg::ST_BUSY || e.status == ssp_pkg::ST_SOFT) begin
            v.status = ssp_pkg::ST_FREE;
            v.owner  = ssp_pkg::ROUTE_NONE;
          end else if (e.status == ssp_pkg::ST_REUSED) begin
            v.status   = ssp_pkg::ST_BUSY;
            v.owner    = e.borrower;
            v.borrower = ssp_pkg::ROUTE_NONE;
          end
        end else if (e.borrower == route) begin
          v.status   = ssp_pkg::ST_SOFT;
          v.borrower = ssp_pkg::ROUTE_NONE;
        end
      end
      default: v = e;
    endcase
  end

  // list sizes -> how many moves each list supplies
  always_comb begin
    cand_sum = 9'(cnt[0]) + 9'(cnt[1]) + 9'(cnt[2]) + 9'(cnt[3]);
    fn_bad   = (func > ssp_pkg::FN_REL_ALL);
    err      = (func != ssp_pkg::FN_REL_ALL) && !fn_bad && (9'(num) > cand_sum);
    t0   = (num < cnt[0]) ? num : cnt[0];
    rem1 = num - t0;
    t1   = (rem1 < cnt[1]) ? rem1 : cnt[1];
    rem2 = rem1 - t1;
    t2   = (rem2 < cnt[2]) ? rem2 : cnt[2];
    case (func)
      ssp_pkg::FN_RESERVE:  err_code = ssp_pkg::RS_RES_SHORT;
      ssp_pkg::FN_PREEMPT:  err_code = ssp_pkg::RS_PRE_EXC;
      ssp_pkg::FN_HARD_REL: err_code = ssp_pkg::RS_HARD_EXC;
      default:              err_code = ssp_pkg::RS_SOFT_EXC;
    endcase
  end

  assign scan_go   = (idx < n_act);
  assign scan_done = !scan_go && !pend;
  assign k_last    = ((k + CW'(1)) == pcount);
  assign thr       = (pool_kind == ssp_pkg::KIND_REPEATER) ? CW'(1) : CW'(0);
  assign skip      = (pool_kind == ssp_pkg::KIND_UNKNOWN) || (pl_rdata == ssp_pkg::ROUTE_NONE);
  assign hit       = (hold <= thr);
  assign out_free  = !o_valid || m_tready;
  assign pl_we     = (state == ssp_pkg::SQ_APPLY) && pend && (func == ssp_pkg::FN_PREEMPT)
                     && q[1];

  always_comb begin
    tbl_req.we    = (state == ssp_pkg::SQ_APPLY) && pend;
    tbl_req.waddr = pidx;
    tbl_req.wdata = v;
    tbl_req.raddr = idx[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ssp_pkg::SQ_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ssp_pkg::SQ_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ssp_pkg::SQ_COUNT;
      end
      ssp_pkg::SQ_COUNT: begin
        if (scan_done) state_next = (err || fn_bad) ? ssp_pkg::SQ_FIN : ssp_pkg::SQ_APPLY;
      end
      ssp_pkg::SQ_APPLY: begin
        if (scan_done) begin
          state_next = (func == ssp_pkg::FN_PREEMPT && pcount != '0) ? ssp_pkg::SQ_PLREAD
                                                                     : ssp_pkg::SQ_FIN;
        end
      end
      ssp_pkg::SQ_PLREAD: state_next = ssp_pkg::SQ_PLWAIT;
      ssp_pkg::SQ_PLWAIT: begin
        if (!skip)      state_next = ssp_pkg::SQ_HOLD;
        else if (k_last) state_next = ssp_pkg::SQ_FIN;
        else             state_next = ssp_pkg::SQ_PLREAD;
      end
      ssp_pkg::SQ_HOLD: begin
        if (scan_done) begin
          if (hit && have_pend) state_next = ssp_pkg::SQ_EMIT;
          else if (k_last)      state_next = ssp_pkg::SQ_FIN;
          else                  state_next = ssp_pkg::SQ_PLREAD;
        end
      end
      ssp_pkg::SQ_EMIT: begin
        if (out_free) state_next = k_last ? ssp_pkg::SQ_FIN : ssp_pkg::SQ_PLREAD;
      end
      ssp_pkg::SQ_FIN: begin
        if (out_free) state_next = ssp_pkg::SQ_IDLE;
      end
      default: state_next = ssp_pkg::SQ_IDLE;
    endcase
  end

  // datapath of the sequencer
  always_ff @(posedge clk) begin
    // slot scan pointer, shared by all passes
    if (scan_go) idx <= idx + CW'(1);
    pend <= scan_go && (state == ssp_pkg::SQ_COUNT || state == ssp_pkg::SQ_APPLY
                        || state == ssp_pkg::SQ_HOLD);
    pidx <= idx[IW-1:0];

    case (state)
      ssp_pkg::SQ_IDLE: begin
        func  <= s_tdata[2:0];
        route <= {1'b0, s_tdata[10:3]};
        num   <= s_tdata[17:11];
        idx   <= '0;
        pend  <= 1'b0;
        cf    <= '0;
        for (int i = 0; i < 4; i++) cnt[i] <= '0;
      end
      ssp_pkg::SQ_COUNT: begin
        if (pend) begin
          for (int i = 0; i < 4; i++) cnt[i] <= cnt[i] + CW'(m[i]);
          cf <= cf + CW'(e.status == ssp_pkg::ST_FREE);
        end
        if (scan_done) begin
          idx        <= '0;
          nf         <= '0;
          pcount     <= '0;
          have_pend  <= 1'b0;
          res_status <= err ? err_code : ssp_pkg::RS_OK;
          res_free   <= cf;
          take[0]    <= t0;
          take[1]    <= t1;
          take[2]    <= t2;
          take[3]    <= rem2 - t2;
          for (int i = 0; i < 4; i++) rank[i] <= '0;
        end
      end
      ssp_pkg::SQ_APPLY: begin
        if (pend) begin
          for (int i = 0; i < 4; i++) rank[i] <= rank[i] + CW'(m[i]);
          nf <= nf + CW'(v.status == ssp_pkg::ST_FREE);
          if (pl_we) pcount <= pcount + CW'(1);
        end
        if (scan_done) begin
          res_free <= nf;
          k        <= '0;
        end
      end
      ssp_pkg::SQ_PLWAIT: begin
        pr   <= pl_rdata;
        idx  <= '0;
        pend <= 1'b0;
        hold <= '0;
        if (skip) k <= k + CW'(1);
      end
      ssp_pkg::SQ_HOLD: begin
        if (pend) hold <= hold + CW'(e.owner == pr || e.borrower == pr);
        if (scan_done) begin
          if (hit && !have_pend) begin
            have_pend  <= 1'b1;
            pend_route <= pr[ssp_pkg::ROUTE_BITS-1:0];
          end
          if (!(hit && have_pend)) k <= k + CW'(1);
        end
      end
      ssp_pkg::SQ_EMIT: begin
        if (out_free) begin
          pend_route <= pr[ssp_pkg::ROUTE_BITS-1:0];
          k          <= k + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // output register; loaded from EMIT (not last) and FIN (last)
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if ((state == ssp_pkg::SQ_EMIT || state == ssp_pkg::SQ_FIN) && out_free) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ssp_pkg::SQ_EMIT || state == ssp_pkg::SQ_FIN) && out_free) begin
      o_status <= (state == ssp_pkg::SQ_FIN) ? res_status : ssp_pkg::RS_OK;
      o_sv     <= have_pend;
      o_route  <= have_pend ? pend_route : '0;
      o_free   <= res_free;
      o_last   <= (state == ssp_pkg::SQ_FIN);
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {6'd0, o_free, o_route, o_status};
  assign m_tuser  = o_sv;
  assign m_tlast  = o_last;

`ifndef SYNTH
  // error results stand alone and never name a route
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_status != ssp_pkg::RS_OK) |-> (m_tlast && !m_tuser))
    else $error("error result not single");

  // one operation at a time: busy right after a transfer in
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while busy");

  // eviction list never overruns the pool
  assert property (@(posedge clk) disable iff (rst)
    (state == ssp_pkg::SQ_APPLY) |-> (pcount <= CW'(ssp_pkg::POOL_SIZE)))
    else $error("eviction list overflow");
`endif

endmodule

FILE: tb/tb.sv
// Testbench for shared_slot_pool_with_preemption: directed and random operations,
// each result checked against a behavioural model of the pool. Depends on ssp_pkg.
`timescale 1ns / 1ps

module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [23:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [6:0]  cfg_wdata = '0;

  shared_slot_pool_with_preemption dut (.*);

  always #5 clk = ~clk;

  typedef struct packed {
    logic [2:0] status;
    logic       stop_valid;
    logic [7:0] stopped_route;
    logic [6:0] free_count;
    logic       last;
  } pool_result_t;

  // model state
  ssp_pkg::slot_state_t      pst [ssp_pkg::POOL_SIZE];
  logic [ssp_pkg::RID_W-1:0] pown[ssp_pkg::POOL_SIZE];
  logic [ssp_pkg::RID_W-1:0] pbor[ssp_pkg::POOL_SIZE];
  int               m_slots;
  logic [1:0]       m_kind;

  pool_result_t pending_results[$];
  int  errors = 0;
  bit  hold_off = 0;
  int  hold_cycles = 0;

  function automatic int n_active();
    return (m_slots > ssp_pkg::POOL_SIZE) ? ssp_pkg::POOL_SIZE : m_slots;
  endfunction

  function automatic logic [6:0] free_now();
    int c;
    c = 0;
    for (int i = 0; i < n_active(); i++) if (pst[i] == ssp_pkg::ST_FREE) c++;
    return 7'(c);
  endfunction

  function automatic int held_by(logic [ssp_pkg::RID_W-1:0] r);
    int c;
    c = 0;
    for (int i = 0; i < n_active(); i++) if (pown[i] == r || pbor[i] == r) c++;
    return c;
  endfunction

  // candidate list: mode 0 any, 1 owner match, 2 borrower match
  function automatic void pick(ref int lst[$], input ssp_pkg::slot_state_t st,
                               input int mode, input logic [ssp_pkg::RID_W-1:0] r);
    lst = {};
    for (int i = 0; i < n_active(); i++) begin
      if (pst[i] != st) continue;
      if (mode == 1 && pown[i] != r) continue;
      if (mode == 2 && pbor[i] != r) continue;
      lst = {lst, i};
    end
  endfunction

  function automatic void push_res(logic [2:0] stt, logic sv, logic [7:0] sr, logic lst);
    pool_result_t p;
    p.status = stt; p.stop_valid = sv; p.stopped_route = sr;
    p.free_count = free_now(); p.last = lst;
    pending_results = {pending_results, p};
  endfunction

  // predict the results of one operation and update the model pool
  function automatic void predict_pool_op(logic [2:0] fn, logic [7:0] rt, logic [6:0] cnt);
    int la[$], lb[$], lc[$], ld[$];
    int ia, ib, ic, id, s, thr, nr;
    logic [ssp_pkg::RID_W-1:0] r, evicted[$];
    r = {1'b0, rt};
    ia = 0; ib = 0; ic = 0; id = 0;
    case (fn)
      ssp_pkg::FN_RESERVE: begin
        pick(la, ssp_pkg::ST_FREE, 0, r); pick(lb, ssp_pkg::ST_SOFT, 0, r);
        if (la.size() + lb.size() < cnt) begin
          push_res(ssp_pkg::RS_RES_SHORT, 0, 0, 1); return;
        end
        for (int k = 0; k < cnt; k++)
          if (ia < la.size()) begin
            s = la[ia++]; pst[s] = ssp_pkg::ST_BUSY; pown[s] = r;
          end else begin
            s = lb[ib++]; pst[s] = ssp_pkg::ST_REUSED; pbor[s] = r;
          end
      end
      ssp_pkg::FN_PREEMPT: begin
        pick(la, ssp_pkg::ST_SOFT, 1, r); pick(lb, ssp_pkg::ST_REUSED, 1, r);
        if (la.size() + lb.size() < cnt) begin
          push_res(ssp_pkg::RS_PRE_EXC, 0, 0, 1); return;
        end
        for (int k = 0; k < cnt; k++)
          if (ia < la.size()) begin
            s = la[ia++]; pst[s] = ssp_pkg::ST_BUSY;
          end else begin
            s = lb[ib++]; evicted = {evicted, pbor[s]};
            pst[s] = ssp_pkg::ST_BUSY; pbor[s] = ssp_pkg::ROUTE_NONE;
          end
        thr = (m_kind == ssp_pkg::KIND_REPEATER) ? 1 : 0;
        nr = 0;
        foreach (evicted[k]) begin
          if (m_kind == ssp_pkg::KIND_UNKNOWN || evicted[k] == ssp_pkg::ROUTE_NONE) continue;
          if (held_by(evicted[k]) <= thr && nr < 64) begin
            push_res(ssp_pkg::RS_OK, 1, evicted[k][7:0], 0); nr++;
          end
        end
        if (nr == 0) push_res(ssp_pkg::RS_OK, 0, 0, 1);
        else pending_results[$].last = 1'b1;
        return;
      end
      ssp_pkg::FN_HARD_REL: begin
        pick(la, ssp_pkg::ST_REUSED, 2, r); pick(lb, ssp_pkg::ST_REUSED, 1, r);
        pick(lc, ssp_pkg::ST_SOFT, 1, r); pick(ld, ssp_pkg::ST_BUSY, 1, r);
        if (la.size() + lb.size() + lc.size() + ld.size() < cnt) begin
          push_res(ssp_pkg::RS_HARD_EXC, 0, 0, 1); return;
        end
        // lists may overlap; each entry acts on the slot as it stands
        for (int k = 0; k < cnt; k++)
          if (ia < la.size()) begin
            s = la[ia++]; pst[s] = ssp_pkg::ST_SOFT; pbor[s] = ssp_pkg::ROUTE_NONE;
          end else if (ib < lb.size()) begin
            s = lb[ib++]; pst[s] = ssp_pkg::ST_BUSY; pown[s] = pbor[s];
            pbor[s] = ssp_pkg::ROUTE_NONE;
          end else if (ic < lc.size()) begin
            s = lc[ic++]; pst[s] = ssp_pkg::ST_FREE; pown[s] = ssp_pkg::ROUTE_NONE;
          end else begin
            s = ld[id++]; pst[s] = ssp_pkg::ST_FREE; pown[s] = ssp_pkg::ROUTE_NONE;
          end
      end
      ssp_pkg::FN_SOFT_REL: begin
        pick(la, ssp_pkg::ST_BUSY, 1, r);
        if (la.size() < cnt) begin push_res(ssp_pkg::RS_SOFT_EXC, 0, 0, 1); return; end
        for (int k = 0; k < cnt; k++) pst[la[k]] = ssp_pkg::ST_SOFT;
      end
      ssp_pkg::FN_REL_ALL: begin
        for (int i = 0; i < n_active(); i++)
          if (pown[i] == r) begin
            if (pst[i] == ssp_pkg::ST_BUSY || pst[i] == ssp_pkg::ST_SOFT) begin
              pst[i] = ssp_pkg::ST_FREE; pown[i] = ssp_pkg::ROUTE_NONE;
            end else if (pst[i] == ssp_pkg::ST_REUSED) begin
              pst[i] = ssp_pkg::ST_BUSY; pown[i] = pbor[i]; pbor[i] = ssp_pkg::ROUTE_NONE;
            end
          end else if (pbor[i] == r) begin
            pst[i] = ssp_pkg::ST_SOFT; pbor[i] = ssp_pkg::ROUTE_NONE;
          end
      end
      default: ;
    endcase
    push_res(ssp_pkg::RS_OK, 0, 0, 1);
  endfunction

  // one input transfer, prediction made at acceptance; tvalid stays up when the
  // next item follows with no gap
  task automatic send_op(logic [2:0] fn, logic [7:0] rt, logic [6:0] cnt, bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 12) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {6'b0, cnt, rt, fn};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_pool_op(fn, rt, cnt);
    @(negedge clk);
  endtask

  // stop sending, wait for all results, then the block's longest tail
  task automatic drain();
    int t;
    t = 0;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0 && t < 200000) begin @(negedge clk); t++; end
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [6:0] val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ssp_pkg::REG_SLOTS) m_slots = val; else m_kind = val[1:0];
  endtask

  // receiver: random stall per result, or a long hold-off
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        hold_cycles++;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        m_tready <= 1'b1;
        @(posedge clk);
        while (!(m_tvalid && m_tready)) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    pool_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer %h", m_tdata);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[2:0] !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, m_tdata[2:0]); errors++;
        end
        if (m_tuser !== exp_r.stop_valid) begin
          $error("stop_valid exp %0d got %0d", exp_r.stop_valid, m_tuser); errors++;
        end
        if (m_tdata[10:3] !== exp_r.stopped_route) begin
          $error("stopped_route exp %0d got %0d", exp_r.stopped_route, m_tdata[10:3]);
          errors++;
        end
        if (m_tdata[17:11] !== exp_r.free_count) begin
          $error("free_count exp %0d got %0d", exp_r.free_count, m_tdata[17:11]); errors++;
        end
        if (m_tlast !== exp_r.last) begin
          $error("last exp %0d got %0d", exp_r.last, m_tlast); errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_op(ssp_pkg::FN_RESERVE, 8'd0, 7'd0);
    send_op(ssp_pkg::FN_RESERVE, 8'd255, 7'd64);         // fill pool
    send_op(ssp_pkg::FN_RESERVE, 8'd1, 7'd1);            // short
    send_op(ssp_pkg::FN_SOFT_REL, 8'd255, 7'd65);        // exceeds
    send_op(ssp_pkg::FN_SOFT_REL, 8'd255, 7'd20);
    send_op(ssp_pkg::FN_RESERVE, 8'd7, 7'd10);           // borrow soft slots
    send_op(ssp_pkg::FN_RESERVE, 8'd8, 7'd10);
    send_op(ssp_pkg::FN_PREEMPT, 8'd255, 7'd127);        // exceeds
    send_op(ssp_pkg::FN_PREEMPT, 8'd255, 7'd20);         // stops 7 and 8, duplicates
    send_op(ssp_pkg::FN_SOFT_REL, 8'd255, 7'd4);
    send_op(ssp_pkg::FN_RESERVE, 8'd255, 7'd2);          // owned and borrowed by same route
    send_op(ssp_pkg::FN_HARD_REL, 8'd255, 7'd3);
    send_op(ssp_pkg::FN_HARD_REL, 8'd9, 7'd1);           // exceeds
    send_op(ssp_pkg::FN_REL_ALL, 8'd255, 7'd99);
    send_op(3'd5, 8'd3, 7'd3);
    send_op(3'd7, 8'd0, 7'd127);
    send_op(ssp_pkg::FN_PREEMPT, 8'd0, 7'd0);
  endtask

  task automatic test_kinds();
    for (int kd = 0; kd < 4; kd++) begin
      write_reg(ssp_pkg::REG_KIND, 7'(kd));
      send_op(ssp_pkg::FN_RESERVE, 8'd1, 7'd8);
      send_op(ssp_pkg::FN_SOFT_REL, 8'd1, 7'd8);
      send_op(ssp_pkg::FN_RESERVE, 8'd2, 7'd3);
      send_op(ssp_pkg::FN_RESERVE, 8'd3, 7'd1);
      send_op(ssp_pkg::FN_PREEMPT, 8'd1, 7'd7);
      send_op(ssp_pkg::FN_REL_ALL, 8'd1, 7'd0);
      send_op(ssp_pkg::FN_REL_ALL, 8'd2, 7'd0);
      send_op(ssp_pkg::FN_REL_ALL, 8'd3, 7'd0);
    end
  endtask

  task automatic test_random(int items);
    logic [2:0] fn;
    logic [7:0] rt;
    logic [6:0] cnt;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) begin
        write_reg(ssp_pkg::REG_SLOTS, 7'($urandom_range(0, 4) == 0 ? $urandom_range(65, 127)
                                                                  : $urandom_range(1, 64)));
        write_reg(ssp_pkg::REG_KIND, 7'($urandom_range(0, 3)));
      end
      fn  = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      rt  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      cnt = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 8));
      send_op(fn, rt, cnt);
    end
  endtask

  // long receiver hold-off while the sender keeps going
  task automatic test_backpressure();
    hold_off = 1;
    fork
      begin
        hold_cycles = 0;
        while (hold_cycles < 2000) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 8; i++) send_op(ssp_pkg::FN_RESERVE, 8'(i), 7'd1, 0);
    join
  endtask

  initial begin
    m_slots = 64; m_kind = 0;
    for (int i = 0; i < ssp_pkg::POOL_SIZE; i++) begin
      pst[i] = ssp_pkg::ST_FREE; pown[i] = ssp_pkg::ROUTE_NONE; pbor[i] = ssp_pkg::ROUTE_NONE;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_kinds();
    write_reg(ssp_pkg::REG_SLOTS, 7'd0);
    send_op(ssp_pkg::FN_RESERVE, 8'd1, 7'd1);
    write_reg(ssp_pkg::REG_SLOTS, 7'd127);
    test_backpressure();
    test_random(100);
    drain();
    if (errors == 0 && pending_results.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
